// ----- rtl/humidity_sensor_readout_sequencer_core_assert.svh -----
// assertion macros used by the readout sequencer checker
`ifndef HUMIDITY_SENSOR_READOUT_SEQUENCER_CORE_ASSERT_SVH
`define HUMIDITY_SENSOR_READOUT_SEQUENCER_CORE_ASSERT_SVH

// concurrent assertion, switched off while reset is asserted
`define HSRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define HSRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hsrs_pkg.sv -----
// types, codes and crc helpers for the humidity sensor readout sequencer
`default_nettype none

package hsrs_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int VALUE_W         = 16;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 48;

  // engine status codes
  localparam logic [1:0] ENG_IDLE  = 2'd0;
  localparam logic [1:0] ENG_ERROR = 2'd2;

  // engine command codes
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_INIT      = 3'd1;
  localparam logic [2:0] CMD_RESET     = 3'd2;
  localparam logic [2:0] CMD_SEND      = 3'd3;
  localparam logic [2:0] CMD_RECV_ACK  = 3'd4;
  localparam logic [2:0] CMD_RECV_NACK = 3'd5;

  localparam logic [7:0] MEAS_TEMP_BYTE = 8'h03;
  localparam logic [7:0] MEAS_RH_BYTE   = 8'h05;
  localparam logic [7:0] CRC_POLY       = 8'h31;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_ENABLED  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELAX_STEPS     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_STEPS   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_READING = 8'd3;

  localparam logic [VALUE_W-1:0] RELAX_STEPS_RST   = 16'd1221;
  localparam logic [VALUE_W-1:0] TIMEOUT_STEPS_RST = 16'd122;
  localparam logic [VALUE_W-1:0] INVALID_RST       = 16'hFFFF;

  // output tdata field positions
  localparam int OUT_CMD_LSB     = 0;
  localparam int OUT_SBYTE_LSB   = 3;
  localparam int OUT_TEMP_LSB    = 11;
  localparam int OUT_HUM_LSB     = 27;
  localparam int OUT_CHANGED_BIT = 43;

  typedef enum logic [12:0] {
    ST_DISABLED = 13'b0000000000001,
    ST_RELAX    = 13'b0000000000010,
    ST_T_INIT   = 13'b0000000000100,
    ST_T_SEND   = 13'b0000000001000,
    ST_T_HIGH   = 13'b0000000010000,
    ST_T_LOW    = 13'b0000000100000,
    ST_T_CHECK  = 13'b0000001000000,
    ST_H_INIT   = 13'b0000010000000,
    ST_H_SEND   = 13'b0000100000000,
    ST_H_HIGH   = 13'b0001000000000,
    ST_H_LOW    = 13'b0010000000000,
    ST_H_CHECK  = 13'b0100000000000,
    ST_CLEAR    = 13'b1000000000000
  } seq_state_t;

  typedef struct packed {
    logic [1:0] engine_status;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]         engine_command;
    logic [7:0]         send_byte;
    logic [VALUE_W-1:0] temperature_raw;
    logic [VALUE_W-1:0] humidity_raw;
    logic               values_changed;
  } result_t;

  typedef struct packed {
    logic               sensor_enabled;
    logic [VALUE_W-1:0] relax_steps;
    logic [VALUE_W-1:0] command_timeout_steps;
    logic [VALUE_W-1:0] invalid_reading;
  } cfg_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ d[7];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      d  = {d[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // crc state after the command byte, worked out at elaboration
  localparam logic [7:0] CRC_SEED_T = crc8_byte(8'h00, MEAS_TEMP_BYTE);
  localparam logic [7:0] CRC_SEED_H = crc8_byte(8'h00, MEAS_RH_BYTE);

endpackage

`default_nettype wire

// ----- rtl/hsrs_in_reg.sv -----
// input register stage holding one step transaction
`default_nettype none

module hsrs_in_reg
  import hsrs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire item_t up_item,
  output logic       down_valid,
  input  wire logic  down_ready,
  output item_t      down_item
);

  logic  valid_r;
  item_t item_r;

  assign up_ready   = !valid_r || down_ready;
  assign down_valid = valid_r;
  assign down_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hsrs_seq.sv -----
// sequence state, step timer, crc check and published values
`default_nettype none

module hsrs_seq
  import hsrs_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step_en,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  localparam int CMP_W = (TIMER_WIDTH > VALUE_W) ? TIMER_WIDTH : VALUE_W;

  seq_state_t             state_r, state_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [VALUE_W-1:0]     tw_r, tw_nxt, hw_r, hw_nxt;
  logic [VALUE_W-1:0]     pt_r, pt_nxt, ph_r, ph_nxt;
  logic [7:0]             crc_r, crc_nxt;
  logic [CMP_W-1:0]       elapsed_ext;
  logic                   relax_done, timeout_hit;
  logic                   idle, err, restart, crc_ok;
  logic [2:0]             cmd;
  logic [7:0]             sbyte, rx;
  logic                   changed;

  assign rx   = item.received_byte;
  assign idle = (item.engine_status == ENG_IDLE);
  assign err  = (item.engine_status == ENG_ERROR);

  // timer counts first, saturating at all ones
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + TIMER_WIDTH'(1);
  assign elapsed_ext = CMP_W'(elapsed_inc);
  assign relax_done  = (elapsed_ext >= CMP_W'(cfg.relax_steps));
  assign timeout_hit = (elapsed_ext >= CMP_W'(cfg.command_timeout_steps));
  assign crc_ok      = (reverse8(crc_r) == rx);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    sbyte     = 8'h00;
    changed   = 1'b0;
    restart   = 1'b0;
    tw_nxt    = tw_r;
    hw_nxt    = hw_r;
    pt_nxt    = pt_r;
    ph_nxt    = ph_r;
    crc_nxt   = crc_r;
    unique case (state_r)
      ST_DISABLED: begin
        if (cfg.sensor_enabled) begin
          state_nxt = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (relax_done) begin
          if (!idle) begin
            cmd       = CMD_RESET;
            state_nxt = ST_CLEAR;
          end else begin
            cmd       = CMD_INIT;
            state_nxt = ST_T_INIT;
          end
        end
      end
      ST_T_INIT, ST_H_INIT: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          cmd       = CMD_SEND;
          restart   = 1'b1;
          sbyte     = (state_r == ST_T_INIT) ? MEAS_TEMP_BYTE : MEAS_RH_BYTE;
          state_nxt = (state_r == ST_T_INIT) ? ST_T_SEND : ST_H_SEND;
        end
      end
      ST_T_SEND, ST_H_SEND: begin
        if (idle) begin
          cmd       = CMD_RECV_ACK;
          state_nxt = (state_r == ST_T_SEND) ? ST_T_HIGH : ST_H_HIGH;
        end else if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (timeout_hit) begin
          cmd       = CMD_RESET;
          state_nxt = ST_CLEAR;
        end
      end
      ST_T_HIGH: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          tw_nxt    = {rx, 8'h00};
          crc_nxt   = crc8_byte(CRC_SEED_T, rx);
          cmd       = CMD_RECV_ACK;
          state_nxt = ST_T_LOW;
        end
      end
      ST_H_HIGH: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          hw_nxt    = {rx, 8'h00};
          crc_nxt   = crc8_byte(CRC_SEED_H, rx);
          cmd       = CMD_RECV_ACK;
          state_nxt = ST_H_LOW;
        end
      end
      ST_T_LOW: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          tw_nxt    = {tw_r[15:8], rx};
          crc_nxt   = crc8_byte(crc_r, rx);
          cmd       = CMD_RECV_NACK;
          state_nxt = ST_T_CHECK;
        end
      end
      ST_H_LOW: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          hw_nxt    = {hw_r[15:8], rx};
          crc_nxt   = crc8_byte(crc_r, rx);
          cmd       = CMD_RECV_NACK;
          state_nxt = ST_H_CHECK;
        end
      end
      ST_T_CHECK: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          if (crc_ok) begin
            restart   = 1'b1;
            cmd       = CMD_INIT;
            state_nxt = ST_H_INIT;
          end else begin
            cmd       = CMD_RESET;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_H_CHECK: begin
        if (err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end else if (idle) begin
          if (crc_ok) begin
            restart   = 1'b1;
            state_nxt = ST_RELAX;
            if (pt_r != tw_r || ph_r != hw_r) begin
              pt_nxt  = tw_r;
              ph_nxt  = hw_r;
              changed = 1'b1;
            end
          end else begin
            cmd       = CMD_RESET;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        // publish the invalid value on every step until the engine settles
        tw_nxt = cfg.invalid_reading;
        hw_nxt = cfg.invalid_reading;
        if (pt_r != cfg.invalid_reading || ph_r != cfg.invalid_reading) begin
          pt_nxt  = cfg.invalid_reading;
          ph_nxt  = cfg.invalid_reading;
          changed = 1'b1;
        end
        if (idle || err) begin
          restart   = 1'b1;
          state_nxt = ST_RELAX;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  assign elapsed_nxt = restart ? '0 : elapsed_inc;

  assign res.engine_command  = cmd;
  assign res.send_byte       = sbyte;
  assign res.temperature_raw = pt_nxt;
  assign res.humidity_raw    = ph_nxt;
  assign res.values_changed  = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_DISABLED;
      elapsed_r <= '0;
      tw_r      <= '0;
      hw_r      <= '0;
      pt_r      <= INVALID_RST;
      ph_r      <= INVALID_RST;
    end else if (step_en) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      tw_r      <= tw_nxt;
      hw_r      <= hw_nxt;
      pt_r      <= pt_nxt;
      ph_r      <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hsrs_out_reg.sv -----
// result register that parts the step logic from the output stream
`default_nettype none

module hsrs_out_reg
  import hsrs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  output logic         space,
  input  wire result_t load_res,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r;
  result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/humidity_sensor_readout_sequencer_core.sv -----
// top level of the humidity sensor readout sequencer
//
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid/in_tready   | in_tdata: status, received byte
//  out_    | master    | out_tvalid/out_tready | out_tdata: command and readings
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// one step transaction is taken every cycle while out_ is not stalled; it is held in
// the input register; a single pass of the step logic fills the output register
// rst_n is synchronous: state goes to disabled, timer and work values to zero,
// published values to all ones, configuration to its reset values
// a stalled output holds its result while one more input transaction is stored
// configuration writes are taken in every cycle
`default_nettype none

module humidity_sensor_readout_sequencer_core
  import hsrs_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] engine_status, [9:2] received_byte, [15:10] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] engine_command, [10:3] send_byte, [26:11] temperature_raw,
  // [42:27] humidity_raw, [43] values_changed, [47:44] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item, stage_item;
  logic    stage_valid, out_space, step_en;
  result_t step_res, out_res;

  assign in_item.engine_status = in_tdata[1:0];
  assign in_item.received_byte = in_tdata[9:2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_enabled        <= 1'b0;
      cfg_r.relax_steps           <= RELAX_STEPS_RST;
      cfg_r.command_timeout_steps <= TIMEOUT_STEPS_RST;
      cfg_r.invalid_reading       <= INVALID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SENSOR_ENABLED:  cfg_r.sensor_enabled        <= cfg_data[0];
        CFG_RELAX_STEPS:     cfg_r.relax_steps           <= cfg_data;
        CFG_TIMEOUT_STEPS:   cfg_r.command_timeout_steps <= cfg_data;
        CFG_INVALID_READING: cfg_r.invalid_reading       <= cfg_data;
        default: begin
          // writes beyond the register list are dropped
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  hsrs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_item    (in_item),
    .down_valid (stage_valid),
    .down_ready (out_space),
    .down_item  (stage_item)
  );

  assign step_en = stage_valid && out_space;

  hsrs_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (stage_item),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  hsrs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .space     (out_space),
    .load_res  (step_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'h0, out_res.values_changed, out_res.humidity_raw,
                      out_res.temperature_raw, out_res.send_byte, out_res.engine_command};

endmodule

`default_nettype wire

// ----- rtl/hsrs_checker.sv -----
// port-level checks for the readout sequencer, bound to the top level
`default_nettype none
`include "humidity_sensor_readout_sequencer_core_assert.svh"

module hsrs_checker
  import hsrs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [2:0] o_cmd;
  logic [7:0] o_sbyte;
  logic       o_changed;

  assign o_cmd     = out_tdata[OUT_CMD_LSB +: 3];
  assign o_sbyte   = out_tdata[OUT_SBYTE_LSB +: 8];
  assign o_changed = out_tdata[OUT_CHANGED_BIT];

  // a stalled result transaction holds
  `HSRS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // no result straight after reset
  `HSRS_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // a command byte travels only with a send command
  `HSRS_ASSERT(a_send_byte, clk, rst_n, out_tvalid |-> (o_cmd == CMD_SEND) ? (o_sbyte == MEAS_TEMP_BYTE || o_sbyte == MEAS_RH_BYTE) : (o_sbyte == 8'h00), "send byte does not match command")

  // values are published only on steps that give the engine no command
  `HSRS_ASSERT(a_publish_quiet, clk, rst_n, out_tvalid && o_changed |-> o_cmd == CMD_NONE, "publish step carried a command")

endmodule

bind humidity_sensor_readout_sequencer_core hsrs_checker u_hsrs_checker (.*);

`default_nettype wire

// ----- bench/tb_humidity_sensor_readout_sequencer_core.sv -----
// self-checking bench for the humidity sensor readout sequencer core
`default_nettype none

module tb_humidity_sensor_readout_sequencer_core;
  import hsrs_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  STAT_BUSY      = 2'd1;
  localparam logic [1:0]  STAT_SPARE     = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  humidity_sensor_readout_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow registers
  logic               en_reg      = 1'b0;
  logic [VALUE_W-1:0] relax_reg   = RELAX_STEPS_RST;
  logic [VALUE_W-1:0] timeout_reg = TIMEOUT_STEPS_RST;
  logic [VALUE_W-1:0] invalid_reg = INVALID_RST;

  // sequencer state as the bench sees it
  seq_state_t         seq    = ST_DISABLED;
  logic [15:0]        steps  = '0;
  logic [VALUE_W-1:0] t_word = '0;
  logic [VALUE_W-1:0] h_word = '0;
  logic [VALUE_W-1:0] t_pub  = INVALID_RST;
  logic [VALUE_W-1:0] h_pub  = INVALID_RST;

  result_t pending_step_results[$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      snd_idle     = 11;
  int      rcv_idle     = 88;
  int      quiet_cycles = 0;

  typedef struct {
    bit                     reg_write;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    item_t                  step_in;
    bit                     fixed;
    result_t                fixed_out;
  } script_row_t;

  script_row_t script[$];

  // crc-8 over command byte and reading, msb first, then bit reversed
  function automatic logic [7:0] check_byte(input logic [7:0] cmd, input logic [15:0] word);
    logic [23:0] bits24;
    logic [7:0]  crc;
    logic [7:0]  flipped;
    logic        fb;
    bits24 = {cmd, word};
    crc    = 8'h00;
    for (int i = 23; i >= 0; i--) begin
      fb  = crc[7] ^ bits24[i];
      crc = {crc[6:0], 1'b0};
      if (fb) crc = crc ^ CRC_POLY;
    end
    for (int i = 0; i < 8; i++) flipped[i] = crc[7-i];
    return flipped;
  endfunction

  function automatic bit publish_work();
    if (t_pub != t_word || h_pub != h_word) begin
      t_pub = t_word;
      h_pub = h_word;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic advance_readout_seq(input item_t it, output result_t r);
    logic idle;
    logic fault;
    logic restart;
    logic [7:0] rx;
    idle    = (it.engine_status == ENG_IDLE);
    fault   = (it.engine_status == ENG_ERROR);
    rx      = it.received_byte;
    restart = 1'b0;
    r       = '0;
    if (steps != 16'hFFFF) steps = steps + 16'd1;
    case (seq)
      ST_DISABLED: if (en_reg) seq = ST_RELAX;
      ST_RELAX: begin
        if (steps >= relax_reg) begin
          if (idle) begin
            r.engine_command = CMD_INIT;
            seq = ST_T_INIT;
          end else begin
            r.engine_command = CMD_RESET;
            seq = ST_CLEAR;
          end
        end
      end
      ST_T_SEND, ST_H_SEND: begin
        if (idle) begin
          r.engine_command = CMD_RECV_ACK;
          if (seq == ST_T_SEND) seq = ST_T_HIGH;
          else seq = ST_H_HIGH;
        end else if (fault) begin
          restart = 1'b1;
          seq = ST_RELAX;
        end else if (steps >= timeout_reg) begin
          r.engine_command = CMD_RESET;
          seq = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        t_word = invalid_reg;
        h_word = invalid_reg;
        r.values_changed = publish_work();
        if (idle || fault) begin
          restart = 1'b1;
          seq = ST_RELAX;
        end
      end
      default: begin
        // the reading states: an engine error drops back to relax
        if (fault) begin
          restart = 1'b1;
          seq = ST_RELAX;
        end else if (idle) begin
          case (seq)
            ST_T_INIT: begin
              r.engine_command = CMD_SEND;
              r.send_byte = MEAS_TEMP_BYTE;
              restart = 1'b1;
              seq = ST_T_SEND;
            end
            ST_H_INIT: begin
              r.engine_command = CMD_SEND;
              r.send_byte = MEAS_RH_BYTE;
              restart = 1'b1;
              seq = ST_H_SEND;
            end
            ST_T_HIGH: begin
              t_word = {rx, 8'h00};
              r.engine_command = CMD_RECV_ACK;
              seq = ST_T_LOW;
            end
            ST_H_HIGH: begin
              h_word = {rx, 8'h00};
              r.engine_command = CMD_RECV_ACK;
              seq = ST_H_LOW;
            end
            ST_T_LOW: begin
              t_word = t_word | {8'h00, rx};
              r.engine_command = CMD_RECV_NACK;
              seq = ST_T_CHECK;
            end
            ST_H_LOW: begin
              h_word = h_word | {8'h00, rx};
              r.engine_command = CMD_RECV_NACK;
              seq = ST_H_CHECK;
            end
            ST_T_CHECK: begin
              if (check_byte(MEAS_TEMP_BYTE, t_word) == rx) begin
                restart = 1'b1;
                r.engine_command = CMD_INIT;
                seq = ST_H_INIT;
              end else begin
                r.engine_command = CMD_RESET;
                seq = ST_CLEAR;
              end
            end
            ST_H_CHECK: begin
              if (check_byte(MEAS_RH_BYTE, h_word) == rx) begin
                restart = 1'b1;
                r.values_changed = publish_work();
                seq = ST_RELAX;
              end else begin
                r.engine_command = CMD_RESET;
                seq = ST_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    if (restart) steps = '0;
    r.temperature_raw = t_pub;
    r.humidity_raw    = h_pub;
  endtask

  // random step, steered so that most check bytes are right
  function automatic item_t next_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) it.engine_status = ENG_IDLE;
    else if (pick < 86) it.engine_status = STAT_BUSY;
    else if (pick < 93) it.engine_status = STAT_SPARE;
    else it.engine_status = ENG_ERROR;
    pick = $urandom_range(0, 99);
    if (seq == ST_T_CHECK && pick < 85) it.received_byte = check_byte(MEAS_TEMP_BYTE, t_word);
    else if (seq == ST_H_CHECK && pick < 85) it.received_byte = check_byte(MEAS_RH_BYTE, h_word);
    else if (pick < 5) it.received_byte = 8'h00;
    else if (pick < 10) it.received_byte = 8'hFF;
    else it.received_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void add_step(input logic [1:0] st, input logic [7:0] rx);
    script_row_t row;
    row = '{default: '0};
    row.step_in.engine_status = st;
    row.step_in.received_byte = rx;
    script.push_back(row);
  endfunction

  function automatic void add_fixed(input logic [1:0] st, input logic [7:0] rx,
                                    input logic [2:0] cmd, input logic [VALUE_W-1:0] t,
                                    input logic [VALUE_W-1:0] h, input logic ch);
    script_row_t row;
    row = '{default: '0};
    row.step_in.engine_status = st;
    row.step_in.received_byte = rx;
    row.fixed = 1'b1;
    row.fixed_out.engine_command  = cmd;
    row.fixed_out.temperature_raw = t;
    row.fixed_out.humidity_raw    = h;
    row.fixed_out.values_changed  = ch;
    script.push_back(row);
  endfunction

  function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.reg_write = 1'b1;
    row.reg_idx   = idx;
    row.reg_val   = val;
    script.push_back(row);
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_step(input item_t it, input bit fixed, input result_t fixed_out);
    result_t predicted;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-10){1'b0}}, it.received_byte, it.engine_status};
    do @(posedge clk); while (!in_tready);
    advance_readout_seq(it, predicted);
    if (fixed) pending_step_results.push_back(fixed_out);
    else pending_step_results.push_back(predicted);
  endtask

  // registers change only once the block has nothing in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_step_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SENSOR_ENABLED:  en_reg      = val[0];
      CFG_RELAX_STEPS:     relax_reg   = val;
      CFG_TIMEOUT_STEPS:   timeout_reg = val;
      CFG_INVALID_READING: invalid_reg = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic en, input logic [15:0] relax,
                               input logic [15:0] tmo, input logic [15:0] inv);
    settle();
    write_reg(CFG_SENSOR_ENABLED, {15'd0, en});
    write_reg(CFG_RELAX_STEPS, relax);
    write_reg(CFG_TIMEOUT_STEPS, tmo);
    write_reg(CFG_INVALID_READING, inv);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.engine_command  = out_tdata[OUT_CMD_LSB +: 3];
      got.send_byte       = out_tdata[OUT_SBYTE_LSB +: 8];
      got.temperature_raw = out_tdata[OUT_TEMP_LSB +: VALUE_W];
      got.humidity_raw    = out_tdata[OUT_HUM_LSB +: VALUE_W];
      got.values_changed  = out_tdata[OUT_CHANGED_BIT];
      if (pending_step_results.size() == 0) begin
        note_mismatch("result with none expected", 16'(got.engine_command), 16'h0);
      end else begin
        want = pending_step_results.pop_front();
        if (got.engine_command != want.engine_command)
          note_mismatch("engine_command", 16'(got.engine_command), 16'(want.engine_command));
        if (got.send_byte != want.send_byte)
          note_mismatch("send_byte", 16'(got.send_byte), 16'(want.send_byte));
        if (got.temperature_raw != want.temperature_raw)
          note_mismatch("temperature_raw", got.temperature_raw, want.temperature_raw);
        if (got.humidity_raw != want.humidity_raw)
          note_mismatch("humidity_raw", got.humidity_raw, want.humidity_raw);
        if (got.values_changed != want.values_changed)
          note_mismatch("values_changed", 16'(got.values_changed), 16'(want.values_changed));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] crc_t;
    logic [7:0] crc_h;
    logic [7:0] crc_bad;
    int         phase;
    int         count;
    crc_t   = check_byte(MEAS_TEMP_BYTE, 16'hFF00);
    crc_h   = check_byte(MEAS_RH_BYTE, 16'h00FF);
    crc_bad = check_byte(MEAS_TEMP_BYTE, 16'h5AA5) ^ 8'hFF;

    // disabled after reset; status three counts as busy
    add_fixed(ENG_IDLE, 8'h00, CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
    add_fixed(STAT_SPARE, 8'hFF, CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
    add_write(CFG_RELAX_STEPS, 16'd1);
    add_write(CFG_TIMEOUT_STEPS, 16'd2);
    add_write(CFG_SENSOR_ENABLED, 16'd1);
    // enable step is silent, then the timer from the disabled spell ends relax at once
    add_fixed(STAT_BUSY, 8'hAA, CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
    add_fixed(ENG_ERROR, 8'h00, CMD_RESET, 16'hFFFF, 16'hFFFF, 1'b0);
    add_step(ENG_ERROR, 8'h55);
    // clearing the enable while running has no effect
    add_write(CFG_SENSOR_ENABLED, 16'd0);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'hFF);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, crc_t);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'hFF);
    add_fixed(ENG_IDLE, crc_h, CMD_NONE, 16'hFF00, 16'h00FF, 1'b1);
    // engine error during a read goes back to relax
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_ERROR, 8'h00);
    // bad check byte on temperature
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h00);
    add_step(ENG_IDLE, 8'h5A);
    add_step(ENG_IDLE, 8'hA5);
    add_fixed(ENG_IDLE, crc_bad, CMD_RESET, 16'hFF00, 16'h00FF, 1'b0);
    add_fixed(ENG_IDLE, 8'h00, CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].reg_write) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_step(script[i].step_in, script[i].fixed, script[i].fixed_out);
      end
    end

    for (phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin snd_idle = 11; rcv_idle = 88; end
        1: begin snd_idle = 88; rcv_idle = 11; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      case (phase % 3)
        0: load_settings(1'b1, 16'd1, 16'd1, 16'h0000);
        1: load_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_settings(1'($urandom_range(0, 1)), 16'($urandom_range(1, 6)),
                               16'($urandom_range(1, 6)), 16'($urandom_range(0, 65535)));
      endcase
      count = (phase % 3 == 1) ? 40 : 270;
      repeat (count) send_step(next_item(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_step_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
